@@ rtl/ipip_pkg.sv @@
// Shared types and constants for the IP-in-IP tunnel encap/decap unit.
`timescale 1ns / 1ps
package ipip_pkg;
    localparam int HOLD_LEN = 54;
    localparam int MAC_LEN  = 14;
    localparam int IP_LEN   = 20;
    localparam logic [15:0] PORT_RESET = 16'd8000;
    localparam logic [0:0] MODE_ENCAP = 1'b0;
    localparam logic [0:0] MODE_DECAP = 1'b1;
    localparam logic [0:0] REG_MODE = 1'b0;
    localparam logic [0:0] REG_PORT = 1'b1;

    // header store access from the flush sequencer
    typedef struct packed {
        logic       rd_en;
        logic [5:0] rd_addr;
    } hs_rd_t;
endpackage

@@ rtl/ipip_hdr_mem.sv @@
// Header store: 54 x 8 synchronous memory, one write and one registered read port.
`timescale 1ns / 1ps
module ipip_hdr_mem import ipip_pkg::*; (
    input  logic       aclk,
    input  logic       wr_en,
    input  logic [5:0] wr_addr,
    input  logic [7:0] wr_data,
    input  hs_rd_t     rd,
    output logic [7:0] rd_data
);
    logic [7:0] mem [HOLD_LEN];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd.rd_en) begin
            rd_data <= mem[rd.rd_addr];
        end
    end
endmodule

@@ rtl/ipip_tunnel_encap_decap_unit.sv @@
// Top level of the IP-in-IP tunnel encap/decap unit: capture, decide, flush, pass.
//
//  channel | dir | ports                              | notes
//  s_      | in  | s_valid s_ready s_in_byte s_in_last| one frame byte per request
//  m_      | out | m_valid m_ready m_out_data ...     | one or two bytes per request
//  apb     | in  | psel penable pwrite paddr pwdata   | mode @0, match_port @4
//
// Buffering bytes are taken one per cycle into the header store. When 54 bytes
// are held or the frame ends, the unit reads the store back one byte a cycle,
// latching fields of interest as they pass, then walks the output sequence,
// taking each byte from the store or the built header and packing bytes into
// output pairs. Passthrough bytes are forwarded one per cycle while m_ready keeps
// up. Reset is synchronous, active low; the store is not cleared. m_ready low
// holds the current output and stalls the sequencer.
`timescale 1ns / 1ps
module ipip_tunnel_encap_decap_unit import ipip_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_in_byte,
    input  logic        s_in_last,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_out_data,
    output logic [1:0]  m_out_count,
    output logic        m_out_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    typedef enum logic [2:0] {ST_BUF, ST_SCAN, ST_EMIT, ST_PASS} state_t;

    state_t      state_reg;
    logic        mode_reg;
    logic [15:0] port_reg;
    logic [5:0]  pos_reg;        // bytes held
    logic        last_reg;       // frame ended inside the held part
    logic [5:0]  scan_reg;       // read address during scan
    logic        scan_vld_reg;   // rd_data valid
    logic [5:0]  scan_idx_reg;   // address of rd_data
    logic [7:0]  mac12_reg, mac13_reg, ihl_reg, proto_reg, p36_reg, p37_reg;
    logic [7:0]  ip_reg [IP_LEN];
    logic [19:0] acc_reg;        // header word sum gathered during scan
    logic [19:0] sum_reg;
    logic [6:0]  oidx_reg;       // output sequence index
    logic [6:0]  olen_reg;
    logic [1:0]  kind_reg;       // 0 pass, 1 encap, 2 decap
    logic        hi_vld_reg;
    logic [7:0]  hi_reg;
    logic        m_valid_reg;
    logic [15:0] m_data_reg;
    logic [1:0]  m_count_reg;
    logic        m_last_reg;

    hs_rd_t      rd;
    logic [7:0]  rd_data;
    logic        s_fire, m_free, wr_en;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_PORT) ? {16'd0, port_reg} : {31'd0, mode_reg};
    assign m_valid = m_valid_reg;
    assign m_out_data = m_data_reg;
    assign m_out_count = m_count_reg;
    assign m_out_last = m_last_reg;
    assign m_free = !m_valid_reg || m_ready;
    assign s_ready = (state_reg == ST_BUF) || (state_reg == ST_PASS && m_free);
    assign s_fire = s_valid && s_ready;
    assign wr_en = s_fire && (state_reg == ST_BUF);

    // source byte index into the store for output position oidx
    logic [6:0] src;
    logic       src_hdr;     // byte comes from built header
    logic [4:0] hidx;
    always_comb begin
        src = oidx_reg;
        src_hdr = 1'b0;
        hidx = 5'd0;
        if (kind_reg == 2'd1 && oidx_reg >= 7'(MAC_LEN)) begin
            if (oidx_reg < 7'(MAC_LEN + IP_LEN)) begin
                src_hdr = 1'b1;
                hidx = 5'(oidx_reg - 7'(MAC_LEN));
            end else begin
                src = oidx_reg - 7'(IP_LEN);
            end
        end else if (kind_reg == 2'd2 && oidx_reg >= 7'(MAC_LEN)) begin
            src = oidx_reg + 7'(IP_LEN);
        end
    end

    // built header byte
    logic [15:0] tl, fold;
    logic [7:0]  hbyte;
    always_comb begin
        tl = {ip_reg[2], ip_reg[3]} + 16'd20;
        fold = ~(sum_reg[15:0] + {12'd0, sum_reg[19:16]});
        case (hidx)
            5'd2:    hbyte = tl[15:8];
            5'd3:    hbyte = tl[7:0];
            5'd9:    hbyte = 8'd4;
            5'd10:   hbyte = fold[15:8];
            5'd11:   hbyte = fold[7:0];
            default: hbyte = ip_reg[hidx];
        endcase
    end

    // checksum term of a scanned header byte; total length and check field
    // are left out here, the new length is added at the decision
    logic [4:0]  sh;
    logic [15:0] sterm;
    always_comb begin
        sh = 5'(scan_idx_reg - 6'(MAC_LEN));
        case (sh)
            5'd2, 5'd3, 5'd10, 5'd11: sterm = 16'd0;
            5'd9:    sterm = 16'd4;
            default: sterm = sh[0] ? {8'd0, rd_data} : {rd_data, 8'd0};
        endcase
    end

    always_comb begin
        rd.rd_en = 1'b0;
        rd.rd_addr = 6'd0;
        if (state_reg == ST_SCAN && scan_reg < pos_reg) begin
            rd.rd_en = 1'b1;
            rd.rd_addr = scan_reg;
        end else if (state_reg == ST_EMIT && !src_hdr) begin
            rd.rd_en = 1'b1;
            rd.rd_addr = src[5:0];
        end
    end

    ipip_hdr_mem u_mem (
        .aclk(aclk), .wr_en(wr_en), .wr_addr(pos_reg), .wr_data(s_in_byte),
        .rd(rd), .rd_data(rd_data)
    );

    // emit sub-step: step 0 issues read, step 1 consumes
    logic        estep_reg;
    logic        ehdr_reg;
    logic [7:0]  ehb_reg;
    logic [7:0]  cur;
    logic        is_ip, enc_m, dec_m;
    logic        e_take_hi, m_load;
    assign cur = ehdr_reg ? ehb_reg : rd_data;
    assign e_take_hi = !hi_vld_reg && (oidx_reg + 7'd1 < olen_reg);
    assign m_load = (state_reg == ST_EMIT && estep_reg && !e_take_hi && m_free) ||
                    (state_reg == ST_PASS && s_fire);
    always_comb begin
        is_ip = pos_reg >= 6'(MAC_LEN + IP_LEN) && mac12_reg == 8'h08 &&
                mac13_reg == 8'h00 && ihl_reg[3:0] == 4'd5;
        enc_m = mode_reg == MODE_ENCAP && is_ip && pos_reg == 6'(HOLD_LEN) &&
                proto_reg == 8'd6 && {p36_reg, p37_reg} == port_reg;
        dec_m = mode_reg == MODE_DECAP && is_ip && proto_reg == 8'd4;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_BUF;
            mode_reg <= MODE_ENCAP;
            port_reg <= PORT_RESET;
            pos_reg <= 6'd0;
            m_valid_reg <= 1'b0;
            sum_reg <= 20'd0;
            scan_vld_reg <= 1'b0;
            estep_reg <= 1'b0;
            hi_vld_reg <= 1'b0;
        end else begin
            if (psel && penable && pwrite) begin
                if (paddr[2] == REG_MODE) mode_reg <= pwdata[0];
                else port_reg <= pwdata[15:0];
            end
            if (m_load) m_valid_reg <= 1'b1;
            else if (m_ready) m_valid_reg <= 1'b0;
            case (state_reg)
                ST_BUF: begin
                    if (s_fire) begin
                        pos_reg <= pos_reg + 6'd1;
                        last_reg <= s_in_last;
                        if (s_in_last || pos_reg == 6'(HOLD_LEN - 1)) begin
                            state_reg <= ST_SCAN;
                            scan_reg <= 6'd0;
                            scan_vld_reg <= 1'b0;
                            acc_reg <= 20'd0;
                        end
                    end
                end
                ST_SCAN: begin
                    scan_vld_reg <= rd.rd_en;
                    scan_idx_reg <= scan_reg;
                    if (rd.rd_en) scan_reg <= scan_reg + 6'd1;
                    if (scan_vld_reg) begin
                        case (scan_idx_reg)
                            6'd12: mac12_reg <= rd_data;
                            6'd13: mac13_reg <= rd_data;
                            6'd14: ihl_reg <= rd_data;
                            6'd23: proto_reg <= rd_data;
                            6'd36: p36_reg <= rd_data;
                            6'd37: p37_reg <= rd_data;
                            default: ;
                        endcase
                        if (scan_idx_reg >= 6'(MAC_LEN) &&
                            scan_idx_reg < 6'(MAC_LEN + IP_LEN)) begin
                            ip_reg[5'(scan_idx_reg - 6'(MAC_LEN))] <= rd_data;
                            acc_reg <= acc_reg + 20'(sterm);
                        end
                    end else if (!rd.rd_en && scan_reg != 6'd0) begin
                        // all bytes seen: decide
                        oidx_reg <= 7'd0;
                        estep_reg <= 1'b0;
                        hi_vld_reg <= 1'b0;
                        if (enc_m) begin
                            kind_reg <= 2'd1;
                            olen_reg <= 7'(HOLD_LEN + IP_LEN);
                            sum_reg <= acc_reg + 20'(tl);
                        end else if (dec_m) begin
                            kind_reg <= 2'd2;
                            olen_reg <= 7'(pos_reg) - 7'(IP_LEN);
                        end else begin
                            kind_reg <= 2'd0;
                            olen_reg <= 7'(pos_reg);
                        end
                        state_reg <= ST_EMIT;
                    end
                end
                ST_EMIT: begin
                    if (!estep_reg) begin
                        ehdr_reg <= src_hdr;
                        ehb_reg <= hbyte;
                        estep_reg <= 1'b1;
                    end else if (e_take_hi) begin
                        hi_reg <= cur;
                        hi_vld_reg <= 1'b1;
                        oidx_reg <= oidx_reg + 7'd1;
                        estep_reg <= 1'b0;
                    end else if (m_free) begin
                        m_data_reg <= hi_vld_reg ? {hi_reg, cur} : {cur, 8'd0};
                        m_count_reg <= hi_vld_reg ? 2'd2 : 2'd1;
                        m_last_reg <= last_reg && (oidx_reg + 7'd1 == olen_reg);
                        hi_vld_reg <= 1'b0;
                        estep_reg <= 1'b0;
                        oidx_reg <= oidx_reg + 7'd1;
                        if (oidx_reg + 7'd1 == olen_reg) begin
                            if (last_reg) begin
                                state_reg <= ST_BUF;
                                pos_reg <= 6'd0;
                            end else begin
                                state_reg <= ST_PASS;
                            end
                        end
                    end
                end
                ST_PASS: begin
                    if (s_fire) begin
                        m_data_reg <= {s_in_byte, 8'd0};
                        m_count_reg <= 2'd1;
                        m_last_reg <= s_in_last;
                        if (s_in_last) begin
                            state_reg <= ST_BUF;
                            pos_reg <= 6'd0;
                        end
                    end
                end
                default: state_reg <= ST_BUF;
            endcase
        end
    end

`ifndef SYNTH
    a_no_in_flush: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_SCAN || state_reg == ST_EMIT) |-> !s_ready)
        else $error("input taken during flush");
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> $stable(m_out_data) && m_valid)
        else $error("output changed under stall");
    a_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= 6'(HOLD_LEN))
        else $error("position overflow");
`endif
endmodule

@@ verif/tb_ipip_tunnel_encap_decap_unit.sv @@
// Testbench for the IP-in-IP tunnel encap/decap unit: byte stream stimulus, predicted output pairs.
`timescale 1ns / 1ps
module tb_ipip_tunnel_encap_decap_unit;
    import ipip_pkg::*;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
    } byte_req_t;

    typedef struct packed {
        logic [15:0] data;
        logic [1:0]  count;
        logic        last;
    } pair_req_t;

    logic        aclk;
    logic        aresetn;
    logic        s_valid;
    logic        s_ready;
    logic [7:0]  s_in_byte;
    logic        s_in_last;
    logic        m_valid;
    logic        m_ready;
    logic [15:0] m_out_data;
    logic [1:0]  m_out_count;
    logic        m_out_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    ipip_tunnel_encap_decap_unit u_dut (.*);

    byte_req_t   pending_bytes[$];
    pair_req_t   expected_pairs[$];
    int          error_count;
    int          cycle_count;
    bit          hold_off;
    int          hold_cnt;
    bit          stall_enable;

    // predictor state
    logic        pred_mode;
    logic [15:0] pred_port;
    int          pred_pos;
    logic [7:0]  pred_store[HOLD_LEN];
    bit          pred_pass;

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    task automatic push_seq(input logic [7:0] seq[$], input bit last);
        pair_req_t p;
        for (int i = 0; i < seq.size(); i += 2) begin
            if (i + 1 < seq.size()) begin
                p.data  = {seq[i], seq[i + 1]};
                p.count = 2'd2;
            end else begin
                p.data  = {seq[i], 8'h00};
                p.count = 2'd1;
            end
            p.last = last && (i + 2 >= seq.size());
            expected_pairs.push_back(p);
        end
    endtask

    task automatic flush_held(input bit last);
        logic [7:0] seq[$];
        logic [7:0] hdr[IP_LEN];
        logic [19:0] sum;
        logic [16:0] fold;
        logic [15:0] tl, csum;
        bit is_ip;
        int len;
        len = pred_pos;
        is_ip = len >= MAC_LEN + IP_LEN && pred_store[12] == 8'h08 &&
                pred_store[13] == 8'h00 && pred_store[14][3:0] == 4'd5;
        if (pred_mode == MODE_ENCAP && is_ip && len >= HOLD_LEN && pred_store[23] == 8'd6 &&
            {pred_store[36], pred_store[37]} == pred_port) begin
            for (int i = 0; i < IP_LEN; i++) hdr[i] = pred_store[MAC_LEN + i];
            tl = {hdr[2], hdr[3]} + 16'd20;
            {hdr[2], hdr[3]} = tl;
            hdr[9] = 8'd4;
            hdr[10] = 8'd0;
            hdr[11] = 8'd0;
            sum = '0;
            for (int i = 0; i < IP_LEN; i += 2) sum += {hdr[i], hdr[i + 1]};
            fold = sum[15:0] + sum[19:16];
            csum = ~fold[15:0];
            {hdr[10], hdr[11]} = csum;
            for (int i = 0; i < MAC_LEN; i++) seq.push_back(pred_store[i]);
            for (int i = 0; i < IP_LEN; i++) seq.push_back(hdr[i]);
            for (int i = MAC_LEN; i < len; i++) seq.push_back(pred_store[i]);
        end else if (pred_mode == MODE_DECAP && is_ip && pred_store[23] == 8'd4) begin
            for (int i = 0; i < MAC_LEN; i++) seq.push_back(pred_store[i]);
            for (int i = MAC_LEN + IP_LEN; i < len; i++) seq.push_back(pred_store[i]);
        end else begin
            for (int i = 0; i < len; i++) seq.push_back(pred_store[i]);
        end
        push_seq(seq, last);
    endtask

    task automatic predict_byte(input byte_req_t b);
        logic [7:0] one[$];
        if (pred_pass) begin
            one.push_back(b.data);
            push_seq(one, b.last);
            if (b.last) begin
                pred_pass = 0;
                pred_pos = 0;
            end
        end else begin
            if (pred_pos >= HOLD_LEN) pred_pos = HOLD_LEN - 1;
            pred_store[pred_pos] = b.data;
            pred_pos++;
            if (pred_pos == HOLD_LEN || b.last) begin
                flush_held(b.last);
                if (b.last) pred_pos = 0;
                else pred_pass = 1;
            end
        end
    endtask

    // driver: bursts with random gaps
    int gap_left;
    int burst_left;
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid    <= 1'b0;
            s_in_byte  <= '0;
            s_in_last  <= 1'b0;
            gap_left   <= 0;
            burst_left <= 0;
        end else begin
            if (s_valid && s_ready) predict_byte({s_in_byte, s_in_last});
            if (!s_valid || s_ready) begin
                if (gap_left > 0) begin
                    s_valid  <= 1'b0;
                    gap_left <= gap_left - 1;
                end else if (pending_bytes.size() > 0) begin
                    s_valid   <= 1'b1;
                    {s_in_byte, s_in_last} <= pending_bytes.pop_front();
                    if (burst_left == 0) begin
                        burst_left <= $urandom_range(1, 40);
                        gap_left   <= ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(0, 6);
                    end else begin
                        burst_left <= burst_left - 1;
                    end
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor and receiver stall pattern
    always @(posedge aclk) begin
        if (!aresetn) begin
            m_ready  <= 1'b0;
            hold_cnt <= 0;
        end else begin
            if (m_valid && m_ready) begin
                pair_req_t e;
                if (expected_pairs.size() == 0) begin
                    $error("unexpected output request data=%h", m_out_data);
                    error_count++;
                end else begin
                    e = expected_pairs.pop_front();
                    if (m_out_data !== e.data) begin
                        $error("out_data expected %h actual %h", e.data, m_out_data);
                        error_count++;
                    end
                    if (m_out_count !== e.count) begin
                        $error("out_count expected %0d actual %0d", e.count, m_out_count);
                        error_count++;
                    end
                    if (m_out_last !== e.last) begin
                        $error("out_last expected %0d actual %0d", e.last, m_out_last);
                        error_count++;
                    end
                end
            end
            // long hold-off, counted here once requested
            if (hold_off && hold_cnt < 400) begin
                m_ready  <= 1'b0;
                hold_cnt <= hold_cnt + 1;
            end else if (!stall_enable) m_ready <= 1'b1;
            else m_ready <= (cycle_count % 11 < 7) ? ($urandom_range(0, 3) != 0) : 1'b0;
        end
    end

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000) begin
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge aclk);
        penable <= 1'b1;
        @(posedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == 3'd0) pred_mode = data[0];
        else pred_port = data[15:0];
    endtask

    task automatic wait_drained();
        while (pending_bytes.size() > 0 || s_valid || expected_pairs.size() > 0)
            @(posedge aclk);
        repeat (40) @(posedge aclk);
    endtask

    // one frame; kind 0 tcp candidate, 1 ipip, 2 noise
    task automatic add_frame(input int len, input int kind, input logic [15:0] port);
        logic [7:0] b;
        for (int i = 0; i < len; i++) begin
            b = 8'($urandom_range(0, 255));
            if (kind < 2) begin
                case (i)
                    12: b = 8'h08;
                    13: b = 8'h00;
                    14: b = {4'($urandom_range(0, 15)), 4'd5};
                    23: b = (kind == 0) ? 8'd6 : 8'd4;
                    36: b = port[15:8];
                    37: b = port[7:0];
                    default: ;
                endcase
                if ($urandom_range(0, 15) == 0 && (i == 12 || i == 13 || i == 14 || i == 23))
                    b = 8'($urandom_range(0, 255));
            end
            pending_bytes.push_back({b, 1'(i == len - 1)});
        end
    endtask

    task automatic random_frame();
        int kind;
        int len;
        kind = $urandom_range(0, 3);
        if (kind == 3) kind = $urandom_range(0, 2);
        case ($urandom_range(0, 5))
            0: len = $urandom_range(1, 33);
            1: len = $urandom_range(34, 54);
            default: len = $urandom_range(54, 70);
        endcase
        add_frame(len, kind, ($urandom_range(0, 4) == 0) ? 16'($urandom) : pred_port);
    endtask

    initial begin
        error_count  = 0;
        cycle_count  = 0;
        hold_off     = 0;
        stall_enable = 0;
        pred_mode    = MODE_ENCAP;
        pred_port    = PORT_RESET;
        pred_pos     = 0;
        pred_pass    = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        aresetn = 1'b0;
        repeat (8) @(posedge aclk);
        aresetn <= 1'b1;

        // directed: reset port encap, extremes, short frames, odd/even lengths
        add_frame(54, 0, PORT_RESET);
        add_frame(55, 0, PORT_RESET);
        pending_bytes.push_back({8'hFF, 1'b1});
        pending_bytes.push_back({8'h00, 1'b1});
        wait_drained();
        apb_write(3'd4, 32'h0000_FFFF);
        add_frame(57, 0, 16'hFFFF);
        wait_drained();
        apb_write(3'd4, 32'h0);
        apb_write(3'd0, 32'h1);
        add_frame(34, 1, 0);
        add_frame(33, 1, 0);
        add_frame(40, 1, 0);
        wait_drained();

        // random phases across settings
        stall_enable = 1;
        for (int ph = 0; ph < 4; ph++) begin
            int quota;
            apb_write(3'd0, 32'(ph % 2));
            apb_write(3'd4, (ph == 2) ? 32'h0 : (ph == 3) ? 32'hFFFF : 32'($urandom));
            quota = pending_bytes.size() + 160 / 4;
            while (pending_bytes.size() < quota) random_frame();
            if (ph == 1) hold_off = 1;
            wait_drained();
        end

        repeat (50) @(posedge aclk);
        if (error_count == 0) $display("Testbench completed without errors");
        else $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule
